[rtl/core/bda_pkg.sv]
package bda_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned BcdW      = DigitW * NumDigits;
  localparam int unsigned CharW     = 6;
  localparam int unsigned BitCntW   = $clog2(ValueW);
  localparam int unsigned DigCntW   = $clog2(NumDigits);

  localparam logic [CharW-1:0]  AsciiZero = CharW'(48);
  localparam logic [CharW-1:0]  AsciiNine = CharW'(57);
  localparam logic [DigitW-1:0] AdjLimit  = DigitW'(5);
  localparam logic [DigitW-1:0] AdjAdd    = DigitW'(3);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StConv = 3'b010,
    StEmit = 3'b100
  } state_e;

endpackage

[rtl/core/binary_to_decimal_ascii.sv]
// Converts one 32-bit unsigned item into its decimal text, one ASCII digit per output
// item, most significant digit first, with leading zeros dropped and the final digit
// marked by last_o. The value is shifted into a ten-digit BCD register one bit per cycle
// (shift and add three), and the BCD register is then shifted out one digit per cycle
// unless out_stall_i holds a digit in the output register, leading zeros included but
// not sent. The input is stalled from acceptance until the final digit has left the BCD
// register, so a new item is not taken while one is in work; the input is accepted again
// while the final digit still waits in the output register.
module binary_to_decimal_ascii (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bda_pkg::ValueW-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bda_pkg::CharW-1:0]  digit_char_o,
  output logic                       last_o
);
  import bda_pkg::*;

  state_e               state_q, state_d;
  logic [ValueW-1:0]    val_q, val_d;
  logic [BcdW-1:0]      bcd_q, bcd_d;
  logic [BcdW-1:0]      bcd_adj;
  logic [BitCntW-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]   dig_cnt_q, dig_cnt_d;
  logic                 started_q, started_d;
  logic                 out_valid_q, out_valid_d;
  logic [CharW-1:0]     char_q, char_d;
  logic                 last_q, last_d;
  logic [DigitW-1:0]    top_digit;
  logic                 emit_last;

  always_comb begin
    logic [DigitW-1:0] dig;
    dig = '0;
    for (int i = 0; i < NumDigits; i++) begin
      dig = bcd_q[DigitW*i +: DigitW];
      bcd_adj[DigitW*i +: DigitW] = (dig >= AdjLimit) ? dig + AdjAdd : dig;
    end
  end

  assign top_digit = bcd_q[BcdW-1 -: DigitW];
  assign emit_last = (dig_cnt_q == DigCntW'(NumDigits - 1));

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          val_d     = value_i;
          bcd_d     = '0;
          bit_cnt_d = '0;
          state_d   = StConv;
        end
      end
      StConv: begin
        bcd_d     = {bcd_adj[BcdW-2:0], val_q[ValueW-1]};
        val_d     = {val_q[ValueW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + BitCntW'(1);
        if (bit_cnt_q == BitCntW'(ValueW - 1)) begin
          dig_cnt_d = '0;
          started_d = 1'b0;
          state_d   = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          if (started_q || (top_digit != '0) || emit_last) begin
            out_valid_d = 1'b1;
            char_d      = CharW'(top_digit) + AsciiZero;
            last_d      = emit_last;
            started_d   = 1'b1;
          end
          bcd_d     = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
          dig_cnt_d = dig_cnt_q + DigCntW'(1);
          if (emit_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

endmodule

[rtl/core/bda_checker.sv]
module bda_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [bda_pkg::ValueW-1:0] value_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [bda_pkg::CharW-1:0]  digit_char_o,
  input logic                       last_o
);
  import bda_pkg::*;

  logic [ValueW-1:0] value_seen;
  assign value_seen = value_i;

  // Every character sent is a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_char_o >= AsciiZero) && (digit_char_o <= AsciiNine))
    else $error("digit_char_o is not a decimal digit");

  // An accepted item keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (value_seen == value_i)) |=> in_stall_o)
    else $error("input not stalled after an item was accepted");

  // The block is ready only after the final digit of the previous item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_stall_o && out_valid_o) |-> last_o)
    else $error("input ready while digits of an item are still pending");

  // A stalled digit holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(digit_char_o) && $stable(last_o)))
    else $error("stalled output item changed");

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (.*);

[sim/testbench.sv]
`timescale 1ns / 100ps

class decimal_text_scoreboard;

  typedef struct packed {
    logic [bda_pkg::CharW-1:0] ch;
    logic                      last;
  } digit_t;

  digit_t digits_due[$];
  int     errors;

  function new();
    errors = 0;
  endfunction

  // Every accepted value queues its decimal digits, most significant first.
  function void note_value(logic [bda_pkg::ValueW-1:0] value);
    int unsigned rem;
    logic [3:0]  rev[bda_pkg::NumDigits];
    int          n;
    digit_t      d;
    rem = value;
    n = 0;
    do begin
      rev[n] = 4'(rem % 10);
      rem = rem / 10;
      n++;
    end while (rem != 0 && n < bda_pkg::NumDigits);
    for (int k = 0; k < n; k++) begin
      d.ch   = bda_pkg::AsciiZero + bda_pkg::CharW'(rev[n - 1 - k]);
      d.last = (k == n - 1);
      digits_due.push_back(d);
    end
  endfunction

  function void check_digit(logic [bda_pkg::CharW-1:0] ch, logic last);
    digit_t d;
    if (digits_due.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected digit: char %0d last %0b", ch, last);
      end
      return;
    end
    d = digits_due.pop_front();
    if (ch !== d.ch || last !== d.last) begin
      errors++;
      if (errors <= 10) begin
        $display("digit mismatch: expected char %0d last %0b, got char %0d last %0b",
                 d.ch, d.last, ch, last);
      end
    end
  endfunction

  function int pending();
    return digits_due.size();
  endfunction

endclass

module testbench;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [bda_pkg::ValueW-1:0] value_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [bda_pkg::CharW-1:0]  digit_char_o;
  logic                       last_o;

  decimal_text_scoreboard sb;

  bit tx_gaps_on;
  bit rx_stalls_on;
  bit hold_req;

  binary_to_decimal_ascii DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .digit_char_o(digit_char_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_digit(digit_char_o, last_o);
    end
  end

  // The receiver either serves a requested long hold-off, a random stall burst, or accepts.
  initial begin
    int hold_left;
    int burst_left;
    hold_left = 0;
    burst_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall_i <= 1'b1;
        burst_left--;
      end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        burst_left = $urandom_range(1, 17) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_value(logic [bda_pkg::ValueW-1:0] v);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_value(v);
  endtask

  function automatic logic [bda_pkg::ValueW-1:0] pick_value();
    longint unsigned lo;
    longint unsigned hi;
    int unsigned     n;
    int unsigned     kind;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      return $urandom();
    end
    n = $urandom_range(1, 10);
    lo = 1;
    repeat (n - 1) lo *= 10;
    hi = lo * 10 - 1;
    if (n == 1) begin
      lo = 0;
    end
    if (hi > 64'hFFFF_FFFF) begin
      hi = 64'hFFFF_FFFF;
    end
    if (kind == 3) begin
      return ($urandom_range(0, 1) != 0) ? lo[31:0] : hi[31:0];
    end
    return 32'(lo + ({$urandom(), $urandom()} % (hi - lo + 1)));
  endfunction

  initial begin
    logic [bda_pkg::ValueW-1:0] corner_values[$];
    int                         drain_cycles;
    sb = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    value_i      = '0;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    hold_req     = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    corner_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd98765,
                      32'd999999999, 32'd1000000000, 32'd1000000001, 32'd1234567890,
                      32'd2147483647, 32'd2147483648, 32'd3999999999, 32'd4000000000,
                      32'd4294967289, 32'd4294967290, 32'd4294967294, 32'd4294967295,
                      32'hAAAA_AAAA, 32'h5555_5555};
    foreach (corner_values[i]) begin
      send_value(corner_values[i]);
    end

    for (int i = 0; i < 340; i++) begin
      tx_gaps_on   = (i < 280) && ((i / 30) % 3 != 2);
      rx_stalls_on = (i < 280) && ((i / 25) % 3 != 1);
      if (i == 100) begin
        tx_gaps_on = 1'b0;
        hold_req = 1'b1;
      end
      if (i > 100 && i < 110) begin
        tx_gaps_on = 1'b0;
      end
      if (i == 200) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      send_value(pick_value());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    drain_cycles = 0;
    while (sb.pending() != 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (60) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
